// ===== design/fbd_pkg.sv =====
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types and constants for the fluid buoyancy and drag unit.
// ----------------------------------------------------------------------------
package fbd_pkg;

  // accept edge to result strobe, in clock cycles
  localparam int FBD_LATENCY = 44;
  localparam int DIV_STAGES  = 32;
  localparam int NLANE       = 4;

  // Q32 constants: g*pi/3, pi/2, g, 1.5
  localparam logic [35:0] K_SB = 36'd44122233294;
  localparam logic [32:0] K_SD = 33'd6746518852;
  localparam logic [35:0] K_PB = 36'd42133629174;
  localparam logic [32:0] K_PD = 33'd6442450944;

  typedef enum logic [1:0] {
    CFG_WATER_PRESENT = 2'd0,
    CFG_WATER_LEVEL   = 2'd1,
    CFG_FLUID_DENSITY = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               body_kind;
    logic signed [31:0] body_y;
    logic [30:0]        radius;
    logic [31:0]        volume;
    logic [31:0]        mass;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } fbd_req_t;

  typedef struct packed {
    logic [30:0]        buoy_accel;
    logic signed [31:0] drag_x;
    logic signed [31:0] drag_y;
    logic signed [31:0] drag_z;
    logic               submerged;
  } fbd_res_t;

  typedef struct packed {
    logic        live;
    logic        kind;
    logic [2:0]  vpos;
    logic [31:0] mass;
  } fbd_ctrl_t;

  typedef logic [2:0][31:0]       fbd_mag_t;
  typedef logic [NLANE-1:0][63:0] fbd_y_t;
  typedef logic [NLANE-1:0][31:0] fbd_quo_t;

endpackage

// ===== design/fbd_geom.sv =====
// ----------------------------------------------------------------------------
// fbd_geom
// Front end: submerged depth, cap terms, velocity magnitudes, then hc^2 or volume.
// ----------------------------------------------------------------------------
module fbd_geom import fbd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_v,
  input  fbd_req_t           req,
  input  logic               water_present,
  input  logic signed [31:0] water_level,
  output logic               out_v,
  output logic [63:0]        q,
  output logic [32:0]        t,
  output fbd_ctrl_t          ctrl,
  output fbd_mag_t           mag
);

  logic signed [33:0] h;
  logic [33:0]        r_x;
  logic [31:0]        r2;
  logic [31:0]        hc;
  logic [32:0]        r3;
  logic               sphere;
  logic               sub;
  logic signed [31:0] vel [3];
  fbd_ctrl_t          ctrl_next;
  fbd_mag_t           mag_next;

  logic               a_v;
  logic [31:0]        a_a;
  logic [32:0]        a_t;
  logic               a_sq;
  fbd_ctrl_t          a_ctrl;
  fbd_mag_t           a_mag;

  always_comb begin
    sphere = !req.body_kind;
    r_x    = {3'b000, req.radius};
    h      = 34'(water_level) - 34'(req.body_y) + r_x;
    r2     = {req.radius, 1'b0};
    // depth clamps at the full diameter
    hc     = (h[32:0] > {1'b0, r2}) ? r2 : h[31:0];
    r3     = {2'b00, req.radius} + {1'b0, r2};
    if (sphere) begin
      sub = !h[33] && (h != '0);
    end else begin
      sub = req.body_y < water_level;
    end
    vel[0] = req.vel_x;
    vel[1] = req.vel_y;
    vel[2] = req.vel_z;
    for (int i = 0; i < 3; i++) begin
      mag_next[i]       = vel[i][31] ? 32'(-vel[i]) : vel[i];
      ctrl_next.vpos[i] = !vel[i][31] && (vel[i] != '0);
    end
    ctrl_next.live = sub && water_present;
    ctrl_next.kind = req.body_kind;
    ctrl_next.mass = (req.mass == '0) ? 32'd1 : req.mass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v   <= 1'b0;
      out_v <= 1'b0;
    end else begin
      a_v   <= in_v;
      out_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    a_a    <= sphere ? hc : req.volume;
    // a point keeps its volume: multiplier of one
    a_t    <= sphere ? (r3 - {1'b0, hc}) : 33'd1;
    a_sq   <= sphere;
    a_ctrl <= ctrl_next;
    a_mag  <= mag_next;
    q      <= a_sq ? (64'(a_a) * 64'(a_a)) : {32'b0, a_a};
    t      <= a_t;
    ctrl   <= a_ctrl;
    mag    <= a_mag;
  end

endmodule

// ===== design/fbd_prod.sv =====
// ----------------------------------------------------------------------------
// fbd_prod
// Wide product chain: cap volume, density, constants and velocity, then the
// per-kind shift and an overflow test against the mass ahead of the divider.
// ----------------------------------------------------------------------------
module fbd_prod import fbd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_v,
  input  logic [63:0]      q,
  input  logic [32:0]      t,
  input  fbd_ctrl_t        in_ctrl,
  input  fbd_mag_t         in_mag,
  input  logic [31:0]      density,
  output logic             out_v,
  output fbd_y_t           y,
  output logic [NLANE-1:0] ovf,
  output fbd_ctrl_t        ctrl
);

  logic            c_v, d_v, e_v, f_v, g_v, h_v, i_v, j_v;
  fbd_ctrl_t       c_ctrl, d_ctrl, e_ctrl, f_ctrl, g_ctrl, h_ctrl, i_ctrl, j_ctrl;
  fbd_mag_t        c_mag, d_mag, e_mag, f_mag, g_mag, h_mag;

  logic [64:0]     c_pp [2];
  logic [96:0]     d_p;
  logic [63:0]     e_pp [4];
  logic [128:0]    f_pd;
  logic [67:0]     g_bb [5];
  logic [64:0]     g_bd [5];
  logic [164:0]    h_bb;
  logic [161:0]    h_bd;
  logic [164:0]    i_bb;
  logic [63:0]     i_dv [3][6];
  logic [164:0]    j_bb;
  logic [193:0]    j_dv [3];

  logic [127:0]    p_pad;
  logic [159:0]    pd_pad;
  logic [191:0]    bd_pad;
  logic [35:0]     kb;
  logic [32:0]     kd;
  logic [128:0]    pd_sum;
  logic [164:0]    bb_sum;
  logic [161:0]    bd_sum;
  logic [193:0]    dv_sum [3];
  logic [164:0]    yb;
  logic [193:0]    yd [3];

  always_comb begin
    p_pad  = {31'b0, d_p};
    pd_pad = {31'b0, f_pd};
    bd_pad = {30'b0, h_bd};
    kb     = f_ctrl.kind ? K_PB : K_SB;
    kd     = f_ctrl.kind ? K_PD : K_SD;
    pd_sum = '0;
    for (int i = 0; i < 4; i++) begin
      pd_sum = pd_sum + (129'(e_pp[i]) << (32 * i));
    end
    bb_sum = '0;
    bd_sum = '0;
    for (int i = 0; i < 5; i++) begin
      bb_sum = bb_sum + (165'(g_bb[i]) << (32 * i));
      bd_sum = bd_sum + (162'(g_bd[i]) << (32 * i));
    end
    for (int c = 0; c < 3; c++) begin
      dv_sum[c] = '0;
      for (int k = 0; k < 6; k++) begin
        dv_sum[c] = dv_sum[c] + (194'(i_dv[c][k]) << (32 * k));
      end
    end
    yb = j_ctrl.kind ? (j_bb >> 32) : (j_bb >> 64);
    for (int c = 0; c < 3; c++) begin
      yd[c] = j_ctrl.kind ? (j_dv[c] >> 48) : (j_dv[c] >> 80);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v   <= 1'b0;
      d_v   <= 1'b0;
      e_v   <= 1'b0;
      f_v   <= 1'b0;
      g_v   <= 1'b0;
      h_v   <= 1'b0;
      i_v   <= 1'b0;
      j_v   <= 1'b0;
      out_v <= 1'b0;
    end else begin
      c_v   <= in_v;
      d_v   <= c_v;
      e_v   <= d_v;
      f_v   <= e_v;
      g_v   <= f_v;
      h_v   <= g_v;
      i_v   <= h_v;
      j_v   <= i_v;
      out_v <= j_v;
    end
  end

  always_ff @(posedge clk) begin
    c_pp[0] <= 65'(q[31:0]) * 65'(t);
    c_pp[1] <= 65'(q[63:32]) * 65'(t);
    c_ctrl  <= in_ctrl;
    c_mag   <= in_mag;

    d_p     <= 97'(c_pp[0]) + (97'(c_pp[1]) << 32);
    d_ctrl  <= c_ctrl;
    d_mag   <= c_mag;

    for (int i = 0; i < 4; i++) begin
      e_pp[i] <= 64'(p_pad[32*i +: 32]) * 64'(density);
    end
    e_ctrl  <= d_ctrl;
    e_mag   <= d_mag;

    f_pd    <= pd_sum;
    f_ctrl  <= e_ctrl;
    f_mag   <= e_mag;

    for (int i = 0; i < 5; i++) begin
      g_bb[i] <= 68'(pd_pad[32*i +: 32]) * 68'(kb);
      g_bd[i] <= 65'(pd_pad[32*i +: 32]) * 65'(kd);
    end
    g_ctrl  <= f_ctrl;
    g_mag   <= f_mag;

    h_bb    <= bb_sum;
    h_bd    <= bd_sum;
    h_ctrl  <= g_ctrl;
    h_mag   <= g_mag;

    i_bb    <= h_bb;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 6; k++) begin
        i_dv[c][k] <= 64'(bd_pad[32*k +: 32]) * 64'(h_mag[c]);
      end
    end
    i_ctrl  <= h_ctrl;

    j_bb    <= i_bb;
    j_dv    <= dv_sum;
    j_ctrl  <= i_ctrl;

    // quotient fits 32 bits only while the shifted product stays below m * 2^32
    y[0]    <= yb[63:0];
    ovf[0]  <= (|yb[164:64]) || (yb[63:32] >= j_ctrl.mass);
    for (int c = 0; c < 3; c++) begin
      y[c+1]   <= yd[c][63:0];
      ovf[c+1] <= (|yd[c][193:64]) || (yd[c][63:32] >= j_ctrl.mass);
    end
    ctrl    <= j_ctrl;
  end

endmodule

// ===== design/fbd_div.sv =====
// ----------------------------------------------------------------------------
// fbd_div
// Pipelined restoring divider, one quotient bit per stage, four lanes sharing
// the same divisor (the body mass).
// ----------------------------------------------------------------------------
module fbd_div import fbd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_v,
  input  fbd_ctrl_t        in_ctrl,
  input  fbd_y_t           y,
  input  logic [NLANE-1:0] in_ovf,
  output logic             out_v,
  output fbd_ctrl_t        ctrl,
  output fbd_quo_t         quo,
  output logic [NLANE-1:0] ovf
);

  logic             st_v    [DIV_STAGES];
  fbd_ctrl_t        st_ctrl [DIV_STAGES];
  logic [NLANE-1:0] st_ovf  [DIV_STAGES];
  logic [31:0]      st_rem  [DIV_STAGES][NLANE];
  logic [31:0]      st_word [DIV_STAGES][NLANE];

  logic [31:0]      src_m    [DIV_STAGES];
  logic [31:0]      src_rem  [DIV_STAGES][NLANE];
  logic [31:0]      src_word [DIV_STAGES][NLANE];
  logic [31:0]      nxt_rem  [DIV_STAGES][NLANE];
  logic [31:0]      nxt_word [DIV_STAGES][NLANE];
  logic [32:0]      r2;

  always_comb begin
    src_m[0] = in_ctrl.mass;
    for (int l = 0; l < NLANE; l++) begin
      src_rem[0][l]  = y[l][63:32];
      src_word[0][l] = y[l][31:0];
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      src_m[s] = st_ctrl[s-1].mass;
      for (int l = 0; l < NLANE; l++) begin
        src_rem[s][l]  = st_rem[s-1][l];
        src_word[s][l] = st_word[s-1][l];
      end
    end
    r2 = '0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        // dividend bits leave at the top, quotient bits enter at the bottom
        r2 = {src_rem[s][l], src_word[s][l][31]};
        if (r2 >= {1'b0, src_m[s]}) begin
          nxt_rem[s][l]  = 32'(r2 - {1'b0, src_m[s]});
          nxt_word[s][l] = {src_word[s][l][30:0], 1'b1};
        end else begin
          nxt_rem[s][l]  = r2[31:0];
          nxt_word[s][l] = {src_word[s][l][30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        st_v[s] <= 1'b0;
      end
    end else begin
      st_v[0] <= in_v;
      for (int s = 1; s < DIV_STAGES; s++) begin
        st_v[s] <= st_v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    st_ctrl[0] <= in_ctrl;
    st_ovf[0]  <= in_ovf;
    for (int s = 1; s < DIV_STAGES; s++) begin
      st_ctrl[s] <= st_ctrl[s-1];
      st_ovf[s]  <= st_ovf[s-1];
    end
    st_rem  <= nxt_rem;
    st_word <= nxt_word;
  end

  always_comb begin
    out_v = st_v[DIV_STAGES-1];
    ctrl  = st_ctrl[DIV_STAGES-1];
    ovf   = st_ovf[DIV_STAGES-1];
    for (int l = 0; l < NLANE; l++) begin
      quo[l] = st_word[DIV_STAGES-1][l];
    end
  end

endmodule

// ===== design/fluid_buoyancy_drag_unit_top.sv =====
// ----------------------------------------------------------------------------
// fluid_buoyancy_drag_unit_top
// Buoyant and linear drag acceleration of a sphere or point body in a fluid.
// ----------------------------------------------------------------------------
// usage:
//   a request is taken on a clock edge with start high and busy low; busy is
//   only high while rst is asserted, so a new body may enter every cycle.
//   each request gives one result on result, marked by done for exactly one
//   cycle; results leave in request order.
//   throughput is one body per cycle: every stage, the multiplier chain and
//   the 32-stage divider (one quotient bit per stage) advance each clock.
//   water_present, water_level and fluid_density are written through cfg_we /
//   cfg_idx / cfg_data; the user must write them only while no request is in
//   flight, as the block does not enforce it. reset empties the pipeline, drops
//   done and loads the default fluid (absent, level zero, density 1000.0).
//   the receiver cannot hold results off: done is never stalled, so each
//   result must be captured in its single strobe cycle.
// ----------------------------------------------------------------------------
module fluid_buoyancy_drag_unit_top import fbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  fbd_req_t    req,
  output logic        done,
  output fbd_res_t    result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  logic               water_present;
  logic signed [31:0] water_level;
  logic [31:0]        fluid_density;

  logic               accept;
  logic               g_v;
  logic [63:0]        g_q;
  logic [32:0]        g_t;
  fbd_ctrl_t          g_ctrl;
  fbd_mag_t           g_mag;
  logic               p_v;
  fbd_y_t             p_y;
  logic [NLANE-1:0]   p_ovf;
  fbd_ctrl_t          p_ctrl;
  logic               d_v;
  fbd_ctrl_t          d_ctrl;
  fbd_quo_t           d_quo;
  logic [NLANE-1:0]   d_ovf;
  fbd_res_t           result_next;
  logic [31:0]        dmag;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      water_present <= 1'b0;
      water_level   <= '0;
      fluid_density <= 32'd65536000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WATER_PRESENT: water_present <= cfg_data[0];
        CFG_WATER_LEVEL:   water_level   <= cfg_data;
        CFG_FLUID_DENSITY: fluid_density <= cfg_data;
        default: ;
      endcase
    end
  end

  fbd_geom u_geom (
    .clk           (clk),
    .rst           (rst),
    .in_v          (accept),
    .req           (req),
    .water_present (water_present),
    .water_level   (water_level),
    .out_v         (g_v),
    .q             (g_q),
    .t             (g_t),
    .ctrl          (g_ctrl),
    .mag           (g_mag)
  );

  fbd_prod u_prod (
    .clk     (clk),
    .rst     (rst),
    .in_v    (g_v),
    .q       (g_q),
    .t       (g_t),
    .in_ctrl (g_ctrl),
    .in_mag  (g_mag),
    .density (fluid_density),
    .out_v   (p_v),
    .y       (p_y),
    .ovf     (p_ovf),
    .ctrl    (p_ctrl)
  );

  fbd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_v    (p_v),
    .in_ctrl (p_ctrl),
    .y       (p_y),
    .in_ovf  (p_ovf),
    .out_v   (d_v),
    .ctrl    (d_ctrl),
    .quo     (d_quo),
    .ovf     (d_ovf)
  );

  logic signed [31:0] drag [3];

  always_comb begin
    dmag = '0;
    for (int c = 0; c < 3; c++) begin
      if (d_ctrl.vpos[c]) begin
        // positive velocity: drag is negative and may reach -2^31
        dmag    = (d_ovf[c+1] || (d_quo[c+1] > 32'h8000_0000)) ? 32'h8000_0000
                                                                : d_quo[c+1];
        drag[c] = -dmag;
      end else begin
        dmag    = (d_ovf[c+1] || d_quo[c+1][31]) ? 32'h7FFF_FFFF : d_quo[c+1];
        drag[c] = dmag;
      end
    end
    if (d_ctrl.live) begin
      result_next.buoy_accel = (d_ovf[0] || d_quo[0][31]) ? 31'h7FFF_FFFF : d_quo[0][30:0];
      result_next.drag_x     = drag[0];
      result_next.drag_y     = drag[1];
      result_next.drag_z     = drag[2];
      result_next.submerged  = 1'b1;
    end else begin
      result_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// ===== design/fbd_chk.sv =====
// ----------------------------------------------------------------------------
// fbd_chk
// Port-level checks on the fluid buoyancy and drag unit, bound to the top.
// ----------------------------------------------------------------------------
module fbd_chk import fbd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input fbd_res_t result
);

  // pipeline empties on reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe straight after reset");

  // every accepted request comes out after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##FBD_LATENCY done)
    else $error("request lost in the pipeline");

  // and no result appears without its request
  a_lat_bwd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, FBD_LATENCY))
    else $error("result without a matching request");

  // a dry or above-surface body gives an all-zero result
  a_dry_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.submerged) |->
      (result.buoy_accel == '0 && result.drag_x == '0 &&
       result.drag_y == '0 && result.drag_z == '0))
    else $error("non-zero acceleration on a body out of the fluid");

endmodule

bind fluid_buoyancy_drag_unit_top fbd_chk u_fbd_chk (.*);
